### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked on every clock edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int VAL_W     = 32;
  localparam int PRI_W     = 16;
  localparam int CNT_OUT_W = 8;
  localparam int STATUS_W  = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic ins;
    logic rem;
  } ctrl_t;

endpackage

### rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying queue requests and their results.
// ----------------------------------------------------------------------------
interface spq_in_if
  import spq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [VAL_W-1:0] entry_value;
  logic signed [PRI_W-1:0] entry_priority;

  modport source (output valid, output req_type, output entry_value,
                  output entry_priority, input ready);
  modport sink   (input valid, input req_type, input entry_value,
                  input entry_priority, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] removed_value;
  logic [STATUS_W-1:0]     status;
  logic [CNT_OUT_W-1:0]    entry_count;

  modport source (output valid, output removed_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input removed_value, input status,
                  input entry_count, output ready);
endinterface

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert,
// left on remove, or captures the inserted entry at its sorted place.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk,
  input  ctrl_t                   ctrl,
  input  logic signed [VAL_W-1:0] new_val,
  input  logic signed [PRI_W-1:0] new_pri,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [PRI_W-1:0] left_pri,
  input  logic                    left_gt,
  input  logic                    left_used,
  input  logic signed [VAL_W-1:0] right_val,
  input  logic signed [PRI_W-1:0] right_pri,
  input  logic                    in_use,
  output logic signed [VAL_W-1:0] val,
  output logic signed [PRI_W-1:0] pri,
  output logic                    gt
);

  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic signed [PRI_W-1:0] pri_r, pri_nxt;

  assign gt  = in_use && (pri_r > new_pri);
  assign val = val_r;
  assign pri = pri_r;

  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    if (ctrl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
        pri_nxt = left_pri;
      end else if ((gt || !in_use) && left_used) begin
        val_nxt = new_val;
        pri_nxt = new_pri;
      end
    end else if (ctrl.rem) begin
      val_nxt = right_val;
      pri_nxt = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

endmodule

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept sorted by ascending signed priority in a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  (sink)  : one request per accept; req_type selects insert or
//                    remove, entry_value/entry_priority are used by insert.
//   out_if (source): one result per request with removed_value, status and
//                    the entry count after the request.
// Equal priorities leave in arrival order. A full insert or empty remove
// changes nothing and reports its status with removed_value zero.
// out_if.valid rises in the cycle after accept. Throughput is one
// request per cycle while results are taken: every cell compares its
// priority against the request and all cells shift in the same cycle.
// in_if.ready is high while the result register is empty or being taken,
// so a stalled receiver holds the result and blocks one request behind it.
// Synchronous reset empties the queue and the result register; entry data
// is left as it is and never read before it is written.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)(
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_if,
  spq_out_if.source out_if
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_vld_r;
  logic signed [VAL_W-1:0] removed_r;
  logic [STATUS_W-1:0]     status_r;

  logic signed [VAL_W-1:0] val_w [DEPTH];
  logic signed [PRI_W-1:0] pri_w [DEPTH];
  logic                    gt_w  [DEPTH];
  logic                    used_w[DEPTH];

  logic  accept, full, empty;
  ctrl_t ctrl;

  assign in_if.ready = !out_vld_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);
  assign ctrl.ins    = accept && (in_if.req_type == REQ_INSERT) && !full;
  assign ctrl.rem    = accept && (in_if.req_type == REQ_REMOVE) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] lv, rv;
    logic signed [PRI_W-1:0] lp, rp;
    logic                    lg, lu;

    assign used_w[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lp = '0;
      assign lg = 1'b0;
      assign lu = 1'b1;
    end else begin : g_mid
      assign lv = val_w[i-1];
      assign lp = pri_w[i-1];
      assign lg = gt_w[i-1];
      assign lu = used_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = val_w[i];
      assign rp = pri_w[i];
    end else begin : g_inner
      assign rv = val_w[i+1];
      assign rp = pri_w[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_val   (in_if.entry_value),
      .new_pri   (in_if.entry_priority),
      .left_val  (lv),
      .left_pri  (lp),
      .left_gt   (lg),
      .left_used (lu),
      .right_val (rv),
      .right_pri (rp),
      .in_use    (used_w[i]),
      .val       (val_w[i]),
      .pri       (pri_w[i]),
      .gt        (gt_w[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_r <= ctrl.rem ? val_w[0] : '0;
      if (in_if.req_type == REQ_INSERT) begin
        status_r <= full ? ST_FULL : ST_INSERTED;
      end else begin
        status_r <= empty ? ST_EMPTY : ST_REMOVED;
      end
    end
  end

  logic [CNT_OUT_W-1:0] count_out_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      count_out_r <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_if.valid         = out_vld_r;
  assign out_if.removed_value = removed_r;
  assign out_if.status        = status_r;
  assign out_if.entry_count   = count_out_r;

endmodule

### rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] removed_value,
  input logic [STATUS_W-1:0]     status,
  input logic [CNT_OUT_W-1:0]    entry_count
);

  logic in_seen;
  assign in_seen = in_valid && in_ready;

  `SPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `SPQ_ASSERT_ALWAYS(a_ready_when_free, !out_valid |-> in_ready)
  `SPQ_ASSERT(a_empty_result,
    out_valid && (status == ST_EMPTY) |-> (entry_count == '0) && (removed_value == '0))
  `SPQ_ASSERT(a_full_result,
    out_valid && (status == ST_FULL) |->
      (entry_count == CNT_OUT_W'(DEPTH)) && (removed_value == '0))
  `SPQ_ASSERT(a_result_follows, in_seen |=> out_valid)

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .removed_value (out_if.removed_value),
  .status        (out_if.status),
  .entry_count   (out_if.entry_count)
);

### tb/spq_result_checker.sv
// ----------------------------------------------------------------------------
// spq_result_checker
// Watches the request and result channels of the sorted priority queue. It
// keeps its own sorted copy of the queue and, for every accepted request,
// works out the result it should produce. Each accepted result is compared
// field by field against the oldest pending one.
// ----------------------------------------------------------------------------
module spq_result_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEF
)(
  input  logic clk,
  input  logic rst_n,
  spq_in_if    req_ch,
  spq_out_if   res_ch,
  output int   mismatch_count,
  output int   pending_count
);

  typedef struct {
    logic signed [VAL_W-1:0] word;
    logic signed [PRI_W-1:0] prio;
  } held_entry_t;

  typedef struct {
    logic signed [VAL_W-1:0] removed_value;
    logic [STATUS_W-1:0]     status;
    logic [CNT_OUT_W-1:0]    entry_count;
  } queue_result_t;

  held_entry_t   held_q[$];
  queue_result_t expected_q[$];

  // Applies one request to the held entries and returns the result it yields.
  function automatic queue_result_t serve_request(
    input logic                    kind,
    input logic signed [VAL_W-1:0] word,
    input logic signed [PRI_W-1:0] prio
  );
    queue_result_t r;
    held_entry_t   e;
    int            pos;
    r.removed_value = '0;
    if (kind == REQ_INSERT) begin
      if (held_q.size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // goes behind every entry of lower or equal priority
        pos = held_q.size();
        while (pos > 0 && held_q[pos-1].prio > prio) pos--;
        e.word = word;
        e.prio = prio;
        held_q.insert(pos, e);
        r.status = ST_INSERTED;
      end
    end else begin
      if (held_q.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        e = held_q.pop_front();
        r.removed_value = e.word;
        r.status = ST_REMOVED;
      end
    end
    r.entry_count = CNT_OUT_W'(held_q.size());
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      held_q.delete();
      expected_q.delete();
      mismatch_count = 0;
    end else begin
      // results first: a request accepted at this edge answers no earlier
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result removed_value %0d status %0d count %0d",
                   $time, res_ch.removed_value, res_ch.status, res_ch.entry_count);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (res_ch.removed_value !== want.removed_value) begin
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, want.removed_value, res_ch.removed_value);
            mismatch_count++;
          end
          if (res_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, res_ch.status);
            mismatch_count++;
          end
          if (res_ch.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_count, res_ch.entry_count);
            mismatch_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_q.push_back(serve_request(req_ch.req_type, req_ch.entry_value,
                                           req_ch.entry_priority));
      end
    end
    pending_count = expected_q.size();
  end

endmodule

### tb/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Drives insert and remove requests into the sorted priority queue with
// random gaps and random result stalls. A short directed sequence covers the
// field extremes, empty removes and equal priorities; random phases then
// fill the queue past full, drain it past empty and mix both.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int RANDOM_REQUESTS = 1350;
  localparam int PHASE_LEN       = 170;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int TAIL_CYCLES     = 10;

  logic clk;
  logic rst_n;
  logic no_idle;
  int   mismatch_count;
  int   pending_count;

  spq_in_if  req_ch ();
  spq_out_if res_ch ();

  sorted_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (res_ch)
  );

  spq_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ch         (req_ch),
    .res_ch         (res_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic send_request(
    input logic                    kind,
    input logic signed [VAL_W-1:0] word,
    input logic signed [PRI_W-1:0] prio
  );
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= kind;
    req_ch.entry_value    <= word;
    req_ch.entry_priority <= prio;
    @(posedge clk);
    while (!(req_ch.valid && req_ch.ready)) @(posedge clk);
    @(negedge clk);
  endtask

  // result receiver: random stall before each result
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int                      phase;
    int                      insert_pct;
    logic                    kind;
    logic signed [VAL_W-1:0] word;
    logic signed [PRI_W-1:0] prio;

    rst_n                 = 1'b0;
    no_idle               = 1'b0;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = REQ_INSERT;
    req_ch.entry_value    = '0;
    req_ch.entry_priority = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty remove with junk fields, extremes, equal priorities
    send_request(REQ_REMOVE, 32'shffffffff, 16'sh7fff);
    send_request(REQ_INSERT, 32'sh7fffffff, 16'sh7fff);
    send_request(REQ_INSERT, 32'sh80000000, 16'sh8000);
    send_request(REQ_INSERT, 32'sh00000000, 16'sh0000);
    send_request(REQ_INSERT, 32'shffffffff, 16'shffff);
    send_request(REQ_INSERT, 32'sd1, 16'sd5);
    send_request(REQ_INSERT, 32'sd2, 16'sd5);
    send_request(REQ_INSERT, 32'sd3, 16'sd5);
    send_request(REQ_INSERT, 32'sh5a5a5a5a, 16'sh8000);
    for (int k = 0; k < 8; k++) begin
      send_request(REQ_REMOVE, 32'($urandom), 16'($urandom));
    end
    send_request(REQ_REMOVE, 32'sh12345678, 16'sh8000);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      phase = i / PHASE_LEN;
      case (phase % 3)
        0:       insert_pct = 97;
        1:       insert_pct = 3;
        default: insert_pct = 50;
      endcase
      no_idle = (phase % 4 == 3);
      kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
      if ($urandom_range(0, 7) == 0)
        word = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      else
        word = $urandom;
      case ($urandom_range(0, 3))
        0:       prio = PRI_W'(int'($urandom_range(0, 4)) - 2);
        1:       prio = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        default: prio = PRI_W'($urandom);
      endcase
      send_request(kind, word, prio);
    end
    no_idle = 1'b0;
    req_ch.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
tb/spq_result_checker.sv
tb/tb_sorted_priority_queue.sv
